// File: rtl/tmcw_pkg.sv
// ----------------------------------------------------------------------------
// tmcw_pkg: shared definitions for the text mode console writer
// Screen geometry, field widths, operation and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tmcw_pkg;

   // Screen geometry.
   localparam int ROWS       = 25;
   localparam int COLUMNS    = 80;
   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int COPY_COUNT = CELL_COUNT - COLUMNS;

   // Field widths.
   localparam int ADDR_W  = $clog2(CELL_COUNT);
   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;
   localparam int OFS_W   = 11;
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 4;
   localparam int CELL_W  = 16;
   localparam int OP_W    = 2;
   localparam int CSR_W   = 2;

   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = CHAR_W'(10);
   localparam logic [CHAR_W-1:0] BLANK_CHAR   = CHAR_W'(32);

   localparam logic [COLOR_W-1:0] FG_RESET = COLOR_W'(15);
   localparam logic [COLOR_W-1:0] BG_RESET = COLOR_W'(0);

   typedef enum logic [OP_W-1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   localparam logic [CSR_W-1:0] CSR_FG = CSR_W'(0);
   localparam logic [CSR_W-1:0] CSR_BG = CSR_W'(1);

endpackage

`default_nettype wire

// File: rtl/text_mode_console_writer.sv
// ----------------------------------------------------------------------------
// text_mode_console_writer: text console engine over a screen store
// Puts characters at a cursor, scrolls, clears and reads back single cells
// of a store of 16-bit character and attribute cells.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake             Word carried
//  -------  ---------  --------------------  ---------------------------------
//  req_     in         req_valid/req_stall   op, ch, cell_index
//  rsp_     out        rsp_valid/rsp_stall   cursor row, column, offset, cell
//  csr_     in         csr_valid/csr_ready   register index, colour value
//
// A character put or an unused operation registers its result in the cycle
// after acceptance, unless the put starts a scroll. A read passes through the
// registered read port of the screen store and then the result register.
// A clear sweeps every cell at one write a cycle; a scroll copies each row
// but the top one up through the single read port and write port and then
// blanks the bottom row. After reset a clearing pass writes zero to all
// CELL_COUNT cells before the first word is taken. The request side is
// stalled while a sweep or read is under way, and also while a result word
// is held by a stalled response side.
//
`default_nettype none

module text_mode_console_writer (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [tmcw_pkg::OP_W-1:0]            req_op,
   input  wire  [tmcw_pkg::CHAR_W-1:0]          req_ch,
   input  wire  [tmcw_pkg::OFS_W-1:0]           req_cell_index,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [tmcw_pkg::ROW_W-1:0]           rsp_cursor_row,
   output logic [tmcw_pkg::COL_W-1:0]           rsp_cursor_col,
   output logic [tmcw_pkg::OFS_W-1:0]           rsp_cursor_offset,
   output logic [tmcw_pkg::CELL_W-1:0]          rsp_cell_data,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [tmcw_pkg::CSR_W-1:0]           csr_index,
   input  wire  [tmcw_pkg::COLOR_W-1:0]         csr_wdata
);

   localparam int AW = tmcw_pkg::ADDR_W;
   localparam logic [AW-1:0] LAST_CELL  = AW'(tmcw_pkg::CELL_COUNT - 1);
   localparam logic [AW-1:0] COPY_END   = AW'(tmcw_pkg::COPY_COUNT);
   localparam logic [AW-1:0] ROW_STRIDE = AW'(tmcw_pkg::COLUMNS);
   localparam logic [tmcw_pkg::ROW_W-1:0] LAST_ROW =
      tmcw_pkg::ROW_W'(tmcw_pkg::ROWS - 1);
   localparam logic [tmcw_pkg::COL_W-1:0] LAST_COL =
      tmcw_pkg::COL_W'(tmcw_pkg::COLUMNS - 1);

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      ST_INIT   = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_READ   = 5'b00100,
      ST_SCROLL = 5'b01000,
      ST_FILL   = 5'b10000
   } state_type;

   state_type                       state_ff, state_in;
   logic [AW-1:0]                   cnt_ff, cnt_in;
   logic [tmcw_pkg::ROW_W-1:0]      row_ff, row_in;
   logic [tmcw_pkg::COL_W-1:0]      col_ff, col_in;
   logic                            copy_pend_ff, copy_pend_in;
   logic [AW-1:0]                   copy_addr_ff, copy_addr_in;
   logic                            read_ok_ff, read_ok_in;
   logic [tmcw_pkg::COLOR_W-1:0]    fg_ff, fg_in;
   logic [tmcw_pkg::COLOR_W-1:0]    bg_ff, bg_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [tmcw_pkg::ROW_W-1:0]      rsp_row_ff;
   logic [tmcw_pkg::COL_W-1:0]      rsp_col_ff;
   logic [tmcw_pkg::OFS_W-1:0]      rsp_ofs_ff, rsp_ofs_in;
   logic [tmcw_pkg::CELL_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                            rsp_load;

   // Screen store: one write port and one registered read port.
   logic [tmcw_pkg::CELL_W-1:0]     screen_mem [tmcw_pkg::CELL_COUNT];
   logic [tmcw_pkg::CELL_W-1:0]     mem_rdata_ff;
   logic                            mem_we;
   logic [AW-1:0]                   mem_waddr;
   logic [AW-1:0]                   mem_raddr;
   logic [tmcw_pkg::CELL_W-1:0]     mem_wdata;

   logic                            req_accept;
   logic [AW-1:0]                   cur_pos;
   logic [tmcw_pkg::CELL_W-1:0]     blank_cell;
   logic                            index_ok;

   // The request side may go ahead only when idle and the result register
   // will be free by the next edge.
   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   // Users must change colours only while the engine is idle (not enforced).
   assign csr_ready  = 1'b1;

   assign cur_pos    = AW'(row_ff) * ROW_STRIDE + AW'(col_ff);
   assign blank_cell = {bg_ff, fg_ff, tmcw_pkg::BLANK_CHAR};
   assign index_ok   = int'(req_cell_index) < tmcw_pkg::CELL_COUNT;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= screen_mem[mem_raddr];
   end

   // Colour registers.
   always_comb begin
      fg_in = fg_ff;
      bg_in = bg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            tmcw_pkg::CSR_FG: fg_in = csr_wdata;
            tmcw_pkg::CSR_BG: bg_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer. A scroll reads the cell one row below and writes it into the
   // cell above in the following cycle, then hands over to the fill sweep for
   // the bottom row; a clear uses the same fill sweep from the first cell.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      copy_pend_in = 1'b0;
      copy_addr_in = copy_addr_ff;
      read_ok_in   = read_ok_ff;
      mem_we       = 1'b0;
      mem_waddr    = cnt_ff;
      mem_wdata    = blank_cell;
      mem_raddr    = '0;
      rsp_load     = 1'b0;
      rsp_data_in  = '0;

      case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            mem_raddr = index_ok ? AW'(req_cell_index) : '0;
            if (req_accept) begin
               case (tmcw_pkg::op_type'(req_op))
                  tmcw_pkg::OP_PUT: begin
                     if (req_ch != tmcw_pkg::NEWLINE_CHAR) begin
                        mem_we    = 1'b1;
                        mem_waddr = cur_pos;
                        mem_wdata = {bg_ff, fg_ff, req_ch};
                     end
                     if (req_ch == tmcw_pkg::NEWLINE_CHAR || col_ff == LAST_COL) begin
                        col_in = '0;
                        if (row_ff == LAST_ROW) begin
                           cnt_in   = '0;
                           state_in = ST_SCROLL;
                        end else begin
                           row_in   = row_ff + tmcw_pkg::ROW_W'(1);
                           rsp_load = 1'b1;
                        end
                     end else begin
                        col_in   = col_ff + tmcw_pkg::COL_W'(1);
                        rsp_load = 1'b1;
                     end
                  end
                  tmcw_pkg::OP_CLEAR: begin
                     row_in   = '0;
                     col_in   = '0;
                     cnt_in   = '0;
                     state_in = ST_FILL;
                  end
                  tmcw_pkg::OP_READ: begin
                     read_ok_in = index_ok;
                     state_in   = ST_READ;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_load    = 1'b1;
            rsp_data_in = read_ok_ff ? mem_rdata_ff : '0;
            state_in    = ST_IDLE;
         end
         ST_SCROLL: begin
            if (copy_pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = copy_addr_ff;
               mem_wdata = mem_rdata_ff;
            end
            if (cnt_ff != COPY_END) begin
               mem_raddr    = cnt_ff + ROW_STRIDE;
               copy_addr_in = cnt_ff;
               copy_pend_in = 1'b1;
               cnt_in       = cnt_ff + AW'(1);
            end else begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            mem_we = 1'b1;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Every result reports the cursor as it stands once the item is done.
   assign rsp_ofs_in   = tmcw_pkg::OFS_W'(AW'(row_in) * ROW_STRIDE + AW'(col_in));
   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || rsp_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         copy_pend_ff <= 1'b0;
         fg_ff        <= tmcw_pkg::FG_RESET;
         bg_ff        <= tmcw_pkg::BG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         copy_pend_ff <= copy_pend_in;
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      copy_addr_ff <= copy_addr_in;
      read_ok_ff   <= read_ok_in;
      if (rsp_load) begin
         rsp_row_ff  <= row_in;
         rsp_col_ff  <= col_in;
         rsp_ofs_ff  <= rsp_ofs_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_col    = rsp_col_ff;
   assign rsp_cursor_offset = rsp_ofs_ff;
   assign rsp_cell_data     = rsp_data_ff;

endmodule

`default_nettype wire

// File: rtl/tmcw_checker.sv
// ----------------------------------------------------------------------------
// tmcw_checker: port-level checks for the text mode console writer
// Watches the request and response words and the cursor they report.
// ----------------------------------------------------------------------------
`default_nettype none

module tmcw_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_valid,
   input wire                            req_stall,
   input wire [tmcw_pkg::OP_W-1:0]       req_op,
   input wire                            rsp_valid,
   input wire                            rsp_stall,
   input wire [tmcw_pkg::ROW_W-1:0]      rsp_cursor_row,
   input wire [tmcw_pkg::COL_W-1:0]      rsp_cursor_col,
   input wire [tmcw_pkg::OFS_W-1:0]      rsp_cursor_offset,
   input wire [tmcw_pkg::CELL_W-1:0]     rsp_cell_data
);

   // A held result word keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cursor_row)
         && $stable(rsp_cursor_col) && $stable(rsp_cursor_offset)
         && $stable(rsp_cell_data))
      else $error("held result word changed");

   // The reported offset agrees with the reported row and column.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cursor_offset ==
         tmcw_pkg::OFS_W'(tmcw_pkg::OFS_W'(rsp_cursor_row) *
            tmcw_pkg::OFS_W'(tmcw_pkg::COLUMNS) + tmcw_pkg::OFS_W'(rsp_cursor_col)))
      else $error("cursor offset does not match row and column");

   // The cursor always stays on the screen.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_cursor_row) < tmcw_pkg::ROWS
         && int'(rsp_cursor_col) < tmcw_pkg::COLUMNS)
      else $error("cursor reported off screen");

   // A clear starts a sweep: no result and no new request in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_op == tmcw_pkg::OP_CLEAR |=> !rsp_valid && req_stall)
      else $error("clear did not start a sweep");

endmodule

bind text_mode_console_writer tmcw_checker u_tmcw_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_op            (req_op),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_cursor_row    (rsp_cursor_row),
   .rsp_cursor_col    (rsp_cursor_col),
   .rsp_cursor_offset (rsp_cursor_offset),
   .rsp_cell_data     (rsp_cell_data)
);

`default_nettype wire
